FILE: design/apr_pkg.sv
package apr_pkg;

    localparam int CoordBits  = 16;
    localparam int SizeBits   = 15;
    localparam int WorkBits   = CoordBits + 2;
    localparam int RegIdxBits = 2;
    localparam int AddrBits   = RegIdxBits + 2;
    localparam int DataBits   = 32;

    localparam logic [RegIdxBits-1:0] REG_OWN_WIDTH  = RegIdxBits'(0);
    localparam logic [RegIdxBits-1:0] REG_OWN_HEIGHT = RegIdxBits'(1);
    localparam logic [RegIdxBits-1:0] REG_RIGID_BOX  = RegIdxBits'(2);

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    localparam logic signed [WorkBits-1:0] WorkOne  = WorkBits'(1);
    localparam logic signed [WorkBits-1:0] CoordMax = WorkBits'((1 << (CoordBits - 1)) - 1);
    localparam logic signed [WorkBits-1:0] CoordMin = ~CoordMax;

    typedef struct packed {
        logic                        mode;
        logic signed [CoordBits-1:0] box_x;
        logic signed [CoordBits-1:0] box_y;
        logic        [SizeBits-1:0]  box_width;
        logic        [SizeBits-1:0]  box_height;
    } req_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] pos_x;
        logic signed [CoordBits-1:0] pos_y;
        logic                        moved;
        logic                        saturated;
    } rsp_t;

    typedef struct packed {
        logic [SizeBits-1:0] own_width;
        logic [SizeBits-1:0] own_height;
        logic                rigid_box;
    } cfg_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] value;
        logic                        sat;
    } clamp_t;

    function automatic clamp_t clamp_coord(input logic signed [WorkBits-1:0] v);
        clamp_t r;
        if (v > CoordMax)
        begin
            r.value = CoordMax[CoordBits-1:0];
            r.sat   = 1'b1;
        end
        else if (v < CoordMin)
        begin
            r.value = CoordMin[CoordBits-1:0];
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = v[CoordBits-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: design/apr_cfg_regs.sv
module apr_cfg_regs
    import apr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [DataBits-1:0] pwdata,
    output logic [DataBits-1:0] prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic [RegIdxBits-1:0] reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[AddrBits-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_OWN_WIDTH:  cfg_next.own_width  = pwdata[SizeBits-1:0];
                REG_OWN_HEIGHT: cfg_next.own_height = pwdata[SizeBits-1:0];
                REG_RIGID_BOX:  cfg_next.rigid_box  = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OWN_WIDTH:  prdata = DataBits'(cfg_reg.own_width);
            REG_OWN_HEIGHT: prdata = DataBits'(cfg_reg.own_height);
            REG_RIGID_BOX:  prdata = DataBits'(cfg_reg.rigid_box);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/apr_solver.sv
module apr_solver
    import apr_pkg::*;
(
    input  req_t                        item,
    input  cfg_t                        cfg,
    input  logic signed [CoordBits-1:0] own_x,
    input  logic signed [CoordBits-1:0] own_y,
    output rsp_t                        result
);

    typedef enum logic [1:0] {
        DIR_POS_X,
        DIR_NEG_X,
        DIR_POS_Y,
        DIR_NEG_Y
    } dir_t;

    logic signed [WorkBits-1:0] ox, oy, bx, by, bw, bh, w, h;
    logic signed [WorkBits-1:0] d_pos_x, d_neg_x, d_pos_y, d_neg_y;
    logic signed [WorkBits-1:0] best_d;
    dir_t                       best_dir;
    logic                       same_box;
    logic                       hit;
    clamp_t                     clamp_x;
    clamp_t                     clamp_y;
    clamp_t                     push_val;

    assign ox = WorkBits'(own_x);
    assign oy = WorkBits'(own_y);
    assign bx = WorkBits'(item.box_x);
    assign by = WorkBits'(item.box_y);
    assign bw = WorkBits'(item.box_width);
    assign bh = WorkBits'(item.box_height);
    assign w  = WorkBits'(cfg.own_width);
    assign h  = WorkBits'(cfg.own_height);

    assign same_box = (bx == ox) && (by == oy) && (bw == w) && (bh == h);
    assign hit      = (ox + w > bx) && (ox <= bx + bw) && (oy + h > by) && (oy <= by + bh);

    assign d_pos_x = bx + bw - ox + WorkOne;
    assign d_neg_x = ox + w - bx;
    assign d_pos_y = by + bh - oy + WorkOne;
    assign d_neg_y = oy + h - by;

    // Strict compares keep the earlier direction on a tie.
    always_comb
    begin
        best_d   = d_pos_x;
        best_dir = DIR_POS_X;
        if (d_neg_x < best_d)
        begin
            best_d   = d_neg_x;
            best_dir = DIR_NEG_X;
        end
        if (d_pos_y < best_d)
        begin
            best_d   = d_pos_y;
            best_dir = DIR_POS_Y;
        end
        if (d_neg_y < best_d)
        begin
            best_dir = DIR_NEG_Y;
        end
    end

    assign clamp_x = clamp_coord(bx);
    assign clamp_y = clamp_coord(by);

    always_comb
    begin
        unique case (best_dir)
            DIR_POS_X: push_val = clamp_coord(bx + bw + WorkOne);
            DIR_NEG_X: push_val = clamp_coord(bx - w);
            DIR_POS_Y: push_val = clamp_coord(by + bh + WorkOne);
            DIR_NEG_Y: push_val = clamp_coord(by - h);
            default:   push_val = '0;
        endcase
    end

    always_comb
    begin
        result.pos_x     = own_x;
        result.pos_y     = own_y;
        result.moved     = 1'b0;
        result.saturated = 1'b0;
        if (item.mode == MODE_LOAD)
        begin
            result.pos_x     = clamp_x.value;
            result.pos_y     = clamp_y.value;
            result.saturated = clamp_x.sat || clamp_y.sat;
        end
        else if (!same_box && !cfg.rigid_box && hit)
        begin
            result.moved     = 1'b1;
            result.saturated = push_val.sat;
            if (best_dir == DIR_POS_X || best_dir == DIR_NEG_X)
            begin
                result.pos_x = push_val.value;
            end
            else
            begin
                result.pos_y = push_val.value;
            end
        end
    end

endmodule

FILE: design/aabb_push_out_resolver.sv
// Channel   Signals                          Payload
// request   req_valid, req_ready, req        mode, box_x, box_y, box_width, box_height
// result    rsp_valid, rsp_ready, rsp        pos_x, pos_y, moved, saturated
// config    psel, penable, pwrite, paddr,    own_width @ 0x0, own_height @ 0x4,
//           pwdata, prdata, pready           rigid_box @ 0x8
//
// One request per cycle is sustained while rsp_ready holds; the request and the result are each registered.
// The own position register is updated in the same cycle the result is registered,
// so the next request sees it without a bubble.
// Reset clears the config registers, the valid flags and the own position to zero.
// A stalled result holds the request stage; a new request is still accepted while
// the request stage is empty.
module aabb_push_out_resolver
    import apr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  req_t                req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rsp_t                rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [DataBits-1:0] pwdata,
    output logic [DataBits-1:0] prdata,
    output logic                pready
);

    cfg_t                        cfg;
    req_t                        item_reg;
    logic                        item_valid_reg;
    logic                        item_valid_next;
    rsp_t                        rsp_reg;
    rsp_t                        solved;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic signed [CoordBits-1:0] own_x_reg;
    logic signed [CoordBits-1:0] own_y_reg;
    logic                        advance;
    logic                        req_take;

    apr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apr_solver u_solver (
        .item   (item_reg),
        .cfg    (cfg),
        .own_x  (own_x_reg),
        .own_y  (own_y_reg),
        .result (solved)
    );

    assign advance   = item_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !item_valid_reg || advance;
    assign req_take  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (req_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            own_x_reg      <= '0;
            own_y_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (advance)
            begin
                own_x_reg <= solved.pos_x;
                own_y_reg <= solved.pos_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            item_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= solved;
        end
    end

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("Processed request did not produce a result.");

    a_blocked_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && rsp_valid_reg && !rsp_ready |=> item_valid_reg)
        else $error("Pending request was lost while the result was stalled.");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (own_x_reg == rsp_reg.pos_x) && (own_y_reg == rsp_reg.pos_y))
        else $error("Pending result disagrees with the own position.");

    a_no_move_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item_reg.mode == MODE_LOAD) |=> !rsp_reg.moved)
        else $error("Load request reported a push.");

endmodule
